// ----- rtl/mrpt_pkg.sv -----
// ----------------------------------------------------------------------------
// mrpt_pkg
// Shared widths, register codes and bundle types of the MRP PD torque block.
// ----------------------------------------------------------------------------
`default_nettype none

package mrpt_pkg;

    localparam int VEC_W      = 24;   // Q4.20 guidance vectors
    localparam int TRQ_W      = 32;   // Q12.20 torque
    localparam int GAIN_W     = 24;   // Q12.12 gains
    localparam int ELEM_W     = 20;   // packed inertia / known torque element
    localparam int PACK_W     = 3 * ELEM_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = PACK_W;
    localparam int NUM_STAGES = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_K        = 3'd0,
        CFG_GAIN_P        = 3'd1,
        CFG_INERTIA_ROW0  = 3'd2,
        CFG_INERTIA_ROW1  = 3'd3,
        CFG_INERTIA_ROW2  = 3'd4,
        CFG_KNOWN_TORQUE  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_k;
        logic [GAIN_W-1:0] gain_p;
        logic [PACK_W-1:0] inertia_row_zero;
        logic [PACK_W-1:0] inertia_row_one;
        logic [PACK_W-1:0] inertia_row_two;
        logic [PACK_W-1:0] known_torque_packed;
    } t_cfg;

    typedef struct packed {
        logic signed [VEC_W-1:0] att_err_x;
        logic signed [VEC_W-1:0] att_err_y;
        logic signed [VEC_W-1:0] att_err_z;
        logic signed [VEC_W-1:0] rate_err_x;
        logic signed [VEC_W-1:0] rate_err_y;
        logic signed [VEC_W-1:0] rate_err_z;
        logic signed [VEC_W-1:0] ref_rate_x;
        logic signed [VEC_W-1:0] ref_rate_y;
        logic signed [VEC_W-1:0] ref_rate_z;
        logic signed [VEC_W-1:0] ref_accel_x;
        logic signed [VEC_W-1:0] ref_accel_y;
        logic signed [VEC_W-1:0] ref_accel_z;
    } t_sample;

    typedef struct packed {
        logic signed [TRQ_W-1:0] torque_x;
        logic signed [TRQ_W-1:0] torque_y;
        logic signed [TRQ_W-1:0] torque_z;
    } t_torque;

    // Per-stage load enables and occupancy of the datapath pipeline.
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] vld;
    } t_stage_ctl;

endpackage

`default_nettype wire

// ----- rtl/mrpt_if.sv -----
// ----------------------------------------------------------------------------
// mrpt channel interfaces
// Valid/ready channels for guidance samples, torque results and register
// writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrpt_in_if import mrpt_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VEC_W-1:0] att_err_x;
    logic signed [VEC_W-1:0] att_err_y;
    logic signed [VEC_W-1:0] att_err_z;
    logic signed [VEC_W-1:0] rate_err_x;
    logic signed [VEC_W-1:0] rate_err_y;
    logic signed [VEC_W-1:0] rate_err_z;
    logic signed [VEC_W-1:0] ref_rate_x;
    logic signed [VEC_W-1:0] ref_rate_y;
    logic signed [VEC_W-1:0] ref_rate_z;
    logic signed [VEC_W-1:0] ref_accel_x;
    logic signed [VEC_W-1:0] ref_accel_y;
    logic signed [VEC_W-1:0] ref_accel_z;

    modport source (
        output valid, att_err_x, att_err_y, att_err_z,
               rate_err_x, rate_err_y, rate_err_z,
               ref_rate_x, ref_rate_y, ref_rate_z,
               ref_accel_x, ref_accel_y, ref_accel_z,
        input  ready
    );
    modport sink (
        input  valid, att_err_x, att_err_y, att_err_z,
               rate_err_x, rate_err_y, rate_err_z,
               ref_rate_x, ref_rate_y, ref_rate_z,
               ref_accel_x, ref_accel_y, ref_accel_z,
        output ready
    );
endinterface

interface mrpt_out_if import mrpt_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [TRQ_W-1:0] torque_x;
    logic signed [TRQ_W-1:0] torque_y;
    logic signed [TRQ_W-1:0] torque_z;

    modport source (output valid, torque_x, torque_y, torque_z, input ready);
    modport sink   (input valid, torque_x, torque_y, torque_z, output ready);
endinterface

interface mrpt_cfg_if import mrpt_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, idx, data, input ready);
    modport sink   (input valid, idx, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/mrpt_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// mrpt_cfg_regs
// Gain, inertia and known torque registers, written over the config channel.
// ----------------------------------------------------------------------------
`default_nettype none

module mrpt_cfg_regs import mrpt_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mrpt_cfg_if.sink   i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.idx))
                CFG_GAIN_K:       r_cfg.gain_k              <= i_cfg.data[GAIN_W-1:0];
                CFG_GAIN_P:       r_cfg.gain_p              <= i_cfg.data[GAIN_W-1:0];
                CFG_INERTIA_ROW0: r_cfg.inertia_row_zero    <= i_cfg.data[PACK_W-1:0];
                CFG_INERTIA_ROW1: r_cfg.inertia_row_one     <= i_cfg.data[PACK_W-1:0];
                CFG_INERTIA_ROW2: r_cfg.inertia_row_two     <= i_cfg.data[PACK_W-1:0];
                CFG_KNOWN_TORQUE: r_cfg.known_torque_packed <= i_cfg.data[PACK_W-1:0];
                default: ;  // unused indexes are dropped
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mrpt_pipe_ctrl.sv -----
// ----------------------------------------------------------------------------
// mrpt_pipe_ctrl
// Valid bits and load enables of the datapath stages. A stage loads when it
// is empty or when the stage after it loads, so bubbles close up on a stall.
// ----------------------------------------------------------------------------
`default_nettype none

module mrpt_pipe_ctrl import mrpt_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_out_ready,
    output t_stage_ctl o_ctl
);

    localparam int LAST = NUM_STAGES - 1;

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;
    logic [NUM_STAGES-1:0] load;

    always_comb begin
        load[LAST] = !r_vld[LAST] || i_out_ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            load[k] = !r_vld[k] || load[k+1];
        end
        n_vld[0] = load[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            n_vld[k] = load[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ctl.load = load;
    assign o_ctl.vld  = r_vld;

    // Items neither appear nor vanish inside the pipeline.
    a_conserve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_valid && load[0]) && !(r_vld[LAST] && i_out_ready)
        |=> $countones(r_vld) == $past($countones(r_vld)))
        else $error("pipeline occupancy changed without a transfer");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && load[0] |=> r_vld[0])
        else $error("accepted sample did not enter the first stage");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld) && !i_out_ready |-> !load[0])
        else $error("full stalled pipeline still accepts");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> r_vld == '0)
        else $error("valid bits not cleared by reset");

endmodule

`default_nettype wire

// ----- rtl/mrpt_datapath.sv -----
// ----------------------------------------------------------------------------
// mrpt_datapath
// Seven register stages: body rate, products, rounding, cross product,
// rounding and inertia products, rounding and final sums, negation with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module mrpt_datapath import mrpt_pkg::*; (
    input  wire logic       i_clk,
    input  wire t_cfg       i_cfg,
    input  wire t_stage_ctl i_ctl,
    input  wire t_sample    i_smp,
    output t_torque         o_trq
);

    // Cyclic neighbor indexes for the cross products.
    localparam int NX1 [3] = '{1, 2, 0};
    localparam int NX2 [3] = '{2, 0, 1};

    localparam logic signed [46:0] HALF_IW = 47'sd128;
    localparam logic signed [49:0] HALF_C2 = 50'sd524288;
    localparam logic signed [49:0] HALF_KP = 50'sd2048;
    localparam logic signed [63:0] HALF_C1 = 64'sd524288;
    localparam logic signed [52:0] HALF_ID = 53'sd128;
    localparam logic signed [46:0] TRQ_MAX = 47'sd2147483647;
    localparam logic signed [46:0] TRQ_MIN = -47'sd2147483648;

    logic signed [VEC_W-1:0]  in_sig [3];
    logic signed [VEC_W-1:0]  in_dw  [3];
    logic signed [VEC_W-1:0]  in_wr  [3];
    logic signed [VEC_W-1:0]  in_ar  [3];
    logic signed [ELEM_W-1:0] m_i    [3][3];
    logic signed [ELEM_W-1:0] l_vec  [3];
    logic signed [VEC_W:0]    gain_k_s;
    logic signed [VEC_W:0]    gain_p_s;

    // Stage 1: registered sample and body rate.
    logic signed [VEC_W-1:0] r1_sig [3];
    logic signed [VEC_W-1:0] r1_dw  [3];
    logic signed [VEC_W-1:0] r1_wr  [3];
    logic signed [VEC_W-1:0] r1_ar  [3];
    logic signed [VEC_W:0]   r1_w   [3];
    // Stage 2: first products.
    logic signed [44:0]      r2_piw [3][3];
    logic signed [48:0]      r2_pc2a [3];
    logic signed [48:0]      r2_pc2b [3];
    logic signed [48:0]      r2_pk  [3];
    logic signed [48:0]      r2_pp  [3];
    logic signed [VEC_W-1:0] r2_wr  [3];
    logic signed [VEC_W-1:0] r2_ar  [3];
    // Stage 3: rounded I*w, w x wr and K/P terms.
    logic signed [46:0]      s3_iw  [3];
    logic signed [49:0]      s3_c2  [3];
    logic signed [49:0]      s3_kp  [3];
    logic signed [38:0]      r3_iw  [3];
    logic signed [29:0]      r3_c2  [3];
    logic signed [37:0]      r3_kp  [3];
    logic signed [VEC_W-1:0] r3_wr  [3];
    logic signed [VEC_W-1:0] r3_ar  [3];
    // Stage 4: wr x Iw products and ar - c2.
    logic signed [62:0]      r4_pc1a [3];
    logic signed [62:0]      r4_pc1b [3];
    logic signed [30:0]      r4_d   [3];
    logic signed [37:0]      r4_kp  [3];
    // Stage 5: rounded c1 and I*d products.
    logic signed [63:0]      s5_c1  [3];
    logic signed [43:0]      r5_c1  [3];
    logic signed [50:0]      r5_pid [3][3];
    logic signed [37:0]      r5_kp  [3];
    // Stage 6: rounded I*d and the remaining terms.
    logic signed [52:0]      s6_id  [3];
    logic signed [44:0]      r6_id  [3];
    logic signed [45:0]      r6_kc  [3];
    // Stage 7: saturated torque.
    logic signed [46:0]      s7_t   [3];
    logic signed [TRQ_W-1:0] r7_trq [3];

    always_comb begin
        in_sig[0] = i_smp.att_err_x;
        in_sig[1] = i_smp.att_err_y;
        in_sig[2] = i_smp.att_err_z;
        in_dw[0]  = i_smp.rate_err_x;
        in_dw[1]  = i_smp.rate_err_y;
        in_dw[2]  = i_smp.rate_err_z;
        in_wr[0]  = i_smp.ref_rate_x;
        in_wr[1]  = i_smp.ref_rate_y;
        in_wr[2]  = i_smp.ref_rate_z;
        in_ar[0]  = i_smp.ref_accel_x;
        in_ar[1]  = i_smp.ref_accel_y;
        in_ar[2]  = i_smp.ref_accel_z;
        for (int j = 0; j < 3; j++) begin
            m_i[0][j] = i_cfg.inertia_row_zero[ELEM_W*j +: ELEM_W];
            m_i[1][j] = i_cfg.inertia_row_one[ELEM_W*j +: ELEM_W];
            m_i[2][j] = i_cfg.inertia_row_two[ELEM_W*j +: ELEM_W];
            l_vec[j]  = i_cfg.known_torque_packed[ELEM_W*j +: ELEM_W];
        end
        gain_k_s = $signed({1'b0, i_cfg.gain_k});
        gain_p_s = $signed({1'b0, i_cfg.gain_p});
    end

    // Rounding adds half an LSB, then the upper bits are the floor.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s3_iw[i] = 47'(r2_piw[i][0]) + 47'(r2_piw[i][1]) + 47'(r2_piw[i][2])
                     + HALF_IW;
            s3_c2[i] = 50'(r2_pc2a[i]) - 50'(r2_pc2b[i]) + HALF_C2;
            s3_kp[i] = 50'(r2_pk[i]) + 50'(r2_pp[i]) + HALF_KP;
            s5_c1[i] = 64'(r4_pc1a[i]) - 64'(r4_pc1b[i]) + HALF_C1;
            s6_id[i] = 53'(r5_pid[i][0]) + 53'(r5_pid[i][1]) + 53'(r5_pid[i][2])
                     + HALF_ID;
            s7_t[i]  = 47'(r6_id[i]) - 47'(r6_kc[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            for (int i = 0; i < 3; i++) begin
                r1_sig[i] <= in_sig[i];
                r1_dw[i]  <= in_dw[i];
                r1_wr[i]  <= in_wr[i];
                r1_ar[i]  <= in_ar[i];
                r1_w[i]   <= 25'(in_dw[i]) + 25'(in_wr[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[1]) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r2_piw[i][j] <= 45'(m_i[i][j]) * 45'(r1_w[j]);
                end
                r2_pc2a[i] <= 49'(r1_w[NX1[i]]) * 49'(r1_wr[NX2[i]]);
                r2_pc2b[i] <= 49'(r1_w[NX2[i]]) * 49'(r1_wr[NX1[i]]);
                r2_pk[i]   <= 49'(gain_k_s) * 49'(r1_sig[i]);
                r2_pp[i]   <= 49'(gain_p_s) * 49'(r1_dw[i]);
                r2_wr[i]   <= r1_wr[i];
                r2_ar[i]   <= r1_ar[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[2]) begin
            for (int i = 0; i < 3; i++) begin
                r3_iw[i] <= s3_iw[i][46:8];
                r3_c2[i] <= s3_c2[i][49:20];
                r3_kp[i] <= s3_kp[i][49:12];
                r3_wr[i] <= r2_wr[i];
                r3_ar[i] <= r2_ar[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[3]) begin
            for (int i = 0; i < 3; i++) begin
                r4_pc1a[i] <= 63'(r3_wr[NX1[i]]) * 63'(r3_iw[NX2[i]]);
                r4_pc1b[i] <= 63'(r3_wr[NX2[i]]) * 63'(r3_iw[NX1[i]]);
                r4_d[i]    <= 31'(r3_ar[i]) - 31'(r3_c2[i]);
                r4_kp[i]   <= r3_kp[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[4]) begin
            for (int i = 0; i < 3; i++) begin
                r5_c1[i] <= s5_c1[i][63:20];
                for (int j = 0; j < 3; j++) begin
                    r5_pid[i][j] <= 51'(m_i[i][j]) * 51'(r4_d[j]);
                end
                r5_kp[i] <= r4_kp[i];
            end
        end
    end

    // The known torque is Q8.12 and moves up to 20 fractional bits exactly.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load[5]) begin
            for (int i = 0; i < 3; i++) begin
                r6_id[i] <= s6_id[i][52:8];
                r6_kc[i] <= 46'(r5_kp[i]) - 46'(r5_c1[i]) + (46'(l_vec[i]) <<< 8);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[6]) begin
            for (int i = 0; i < 3; i++) begin
                if (s7_t[i] > TRQ_MAX) begin
                    r7_trq[i] <= TRQ_MAX[TRQ_W-1:0];
                end else if (s7_t[i] < TRQ_MIN) begin
                    r7_trq[i] <= TRQ_MIN[TRQ_W-1:0];
                end else begin
                    r7_trq[i] <= s7_t[i][TRQ_W-1:0];
                end
            end
        end
    end

    assign o_trq.torque_x = r7_trq[0];
    assign o_trq.torque_y = r7_trq[1];
    assign o_trq.torque_z = r7_trq[2];

endmodule

`default_nettype wire

// ----- rtl/mrp_pd_attitude_torque.sv -----
// ----------------------------------------------------------------------------
// mrp_pd_attitude_torque
// MRP proportional-derivative attitude control law in fixed point:
// T = -(K*sigma + P*dw - wr x (I*w) - I*(ar - w x wr) + L), w = dw + wr.
//
//   Channel | Dir | Payload                                  | Transfer
//   i_in    | in  | att_err, rate_err, ref_rate, ref_accel   | valid & ready
//   o_out   | out | torque_x/y/z, Q12.20, saturated          | valid & ready
//   i_cfg   | in  | idx (register 0..5), data (60 bits)      | valid & ready
//
// One sample is taken per cycle unless the pipeline is full and the output
// stalls; each result passes through the multiply and round stages of the datapath.
// Reset clears the pipeline valid bits and all configuration registers.
// A stalled output holds the last stage; earlier stages keep filling any
// empty slots, so input transfers continue until the pipeline is full.
// The config port is always ready; writes to indexes six and seven are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module mrp_pd_attitude_torque import mrpt_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mrpt_in_if.sink    i_in,
    mrpt_out_if.source o_out,
    mrpt_cfg_if.sink   i_cfg
);

    t_cfg       cfg;
    t_stage_ctl ctl;
    t_sample    smp;
    t_torque    trq;

    mrpt_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    mrpt_pipe_ctrl u_pipe_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_ctl       (ctl)
    );

    assign smp.att_err_x   = i_in.att_err_x;
    assign smp.att_err_y   = i_in.att_err_y;
    assign smp.att_err_z   = i_in.att_err_z;
    assign smp.rate_err_x  = i_in.rate_err_x;
    assign smp.rate_err_y  = i_in.rate_err_y;
    assign smp.rate_err_z  = i_in.rate_err_z;
    assign smp.ref_rate_x  = i_in.ref_rate_x;
    assign smp.ref_rate_y  = i_in.ref_rate_y;
    assign smp.ref_rate_z  = i_in.ref_rate_z;
    assign smp.ref_accel_x = i_in.ref_accel_x;
    assign smp.ref_accel_y = i_in.ref_accel_y;
    assign smp.ref_accel_z = i_in.ref_accel_z;

    mrpt_datapath u_datapath (
        .i_clk (i_clk),
        .i_cfg (cfg),
        .i_ctl (ctl),
        .i_smp (smp),
        .o_trq (trq)
    );

    assign i_in.ready     = ctl.load[0];
    assign o_out.valid    = ctl.vld[NUM_STAGES-1];
    assign o_out.torque_x = trq.torque_x;
    assign o_out.torque_y = trq.torque_y;
    assign o_out.torque_z = trq.torque_z;

endmodule

`default_nettype wire
